[hw/rtl/adp_alu_pkg.sv]
package adp_alu_pkg;

    // Data-processing opcodes, standard encoding.
    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_ADC = 4'd5;
    localparam logic [3:0] OP_SBC = 4'd6;
    localparam logic [3:0] OP_RSC = 4'd7;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_CMN = 4'd11;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;
    localparam logic [3:0] OP_BIC = 4'd14;
    localparam logic [3:0] OP_MVN = 4'd15;

    // Shift types.
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // One input item.
    typedef struct packed {
        logic [3:0]  opcode;
        logic [31:0] operand_first;
        logic [31:0] operand_second;
        logic        immediate_form;
        logic [1:0]  shift_kind;
        logic [7:0]  shift_amount;
        logic        shift_by_register;
        logic [3:0]  rotate_amount;
        logic        carry_in;
        logic        overflow_in;
        logic        set_flags;
    } t_alu_in;

    // One result item.
    typedef struct packed {
        logic [31:0] result;
        logic        write_result;
        logic        flags_write;
        logic        flag_n;
        logic        flag_z;
        logic        flag_c;
        logic        flag_v;
    } t_alu_out;

    // Shifter output handed to the ALU.
    typedef struct packed {
        logic [31:0] operand;
        logic        carry;
    } t_shift_res;

    // Rotate right by 0 to 31 places.
    function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

endpackage

[hw/rtl/arm_data_processing_alu_core.sv]
// Data-processing execute stage: barrel shifter and ALU between two registers.
// The item passes through the input register and then the result register.
// Throughput: one item per cycle; busy stays low, so an item may be started every cycle.
// The result is shown for one cycle under o_valid and the receiver cannot stall it.
// Reset (synchronous, active low) clears both valid flags; payload registers keep no reset.
module arm_data_processing_alu_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  adp_alu_pkg::t_alu_in  i_item,
    output logic                  o_valid,
    output adp_alu_pkg::t_alu_out o_result
);

    logic                    r_in_valid;
    adp_alu_pkg::t_alu_in    r_in;
    logic                    r_out_valid;
    adp_alu_pkg::t_alu_out   r_out;
    adp_alu_pkg::t_shift_res shift_res;
    adp_alu_pkg::t_alu_out   n_out;

    // Each stage moves on every cycle, so the block never holds off an item.
    assign busy = 1'b0;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start & ~busy;
        end
        if (start & ~busy) begin
            r_in <= i_item;
        end
    end

    // Second operand from the barrel shifter.
    adp_alu_shifter u_shifter (
        .i_item  (r_in),
        .o_shift (shift_res)
    );

    // Operation and flags.
    adp_alu_exec u_exec (
        .i_item   (r_in),
        .i_shift  (shift_res),
        .o_result (n_out)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[hw/rtl/adp_alu_shifter.sv]
module adp_alu_shifter (
    input  adp_alu_pkg::t_alu_in    i_item,
    output adp_alu_pkg::t_shift_res o_shift
);

    logic [31:0] rm;
    logic        sign;
    logic [4:0]  amt;
    logic [7:0]  amt_reg;
    logic [31:0] val_lsl;
    logic [31:0] val_lsr;
    logic [31:0] val_asr;
    logic [31:0] val_ror;
    logic        c_left;
    logic        c_right;
    logic [4:0]  rot;
    logic [31:0] val_imm;
    logic        amt_zero;

    // The low five bits of the amount drive all in-range shifts of both forms.
    assign rm       = i_item.operand_second;
    assign sign     = rm[31];
    assign amt      = i_item.shift_amount[4:0];
    assign amt_reg  = i_item.shift_amount;
    assign amt_zero = (amt == 5'd0);
    assign val_lsl  = rm << amt;
    assign val_lsr  = rm >> amt;
    assign val_asr  = $unsigned($signed(rm) >>> amt);
    assign val_ror  = adp_alu_pkg::ror32(rm, amt);
    assign c_left   = rm[5'd0 - amt];
    assign c_right  = rm[amt - 5'd1];

    // Rotated 8-bit immediate.
    assign rot     = {i_item.rotate_amount, 1'b0};
    assign val_imm = adp_alu_pkg::ror32({24'd0, rm[7:0]}, rot);

    // Select the second operand and the shifter carry-out.
    always_comb begin
        o_shift.operand = rm;
        o_shift.carry   = i_item.carry_in;
        if (i_item.immediate_form) begin
            o_shift.operand = val_imm;
            o_shift.carry   = (rot == 5'd0) ? i_item.carry_in : val_imm[31];
        end else if (!i_item.shift_by_register) begin
            // Immediate amount: zero encodes LSR #32, ASR #32 and RRX.
            case (i_item.shift_kind)
                adp_alu_pkg::SH_LSL: begin
                    if (!amt_zero) begin
                        o_shift.operand = val_lsl;
                        o_shift.carry   = c_left;
                    end
                end
                adp_alu_pkg::SH_LSR: begin
                    o_shift.operand = amt_zero ? 32'd0 : val_lsr;
                    o_shift.carry   = amt_zero ? sign : c_right;
                end
                adp_alu_pkg::SH_ASR: begin
                    o_shift.operand = amt_zero ? {32{sign}} : val_asr;
                    o_shift.carry   = amt_zero ? sign : c_right;
                end
                default: begin
                    o_shift.operand = amt_zero ? {i_item.carry_in, rm[31:1]} : val_ror;
                    o_shift.carry   = amt_zero ? rm[0] : c_right;
                end
            endcase
        end else if (amt_reg != 8'd0) begin
            // Register amount: all eight bits count, 32 and above are special.
            case (i_item.shift_kind)
                adp_alu_pkg::SH_LSL: begin
                    if (amt_reg < 8'd32) begin
                        o_shift.operand = val_lsl;
                        o_shift.carry   = c_left;
                    end else begin
                        o_shift.operand = 32'd0;
                        o_shift.carry   = (amt_reg == 8'd32) ? rm[0] : 1'b0;
                    end
                end
                adp_alu_pkg::SH_LSR: begin
                    if (amt_reg < 8'd32) begin
                        o_shift.operand = val_lsr;
                        o_shift.carry   = c_right;
                    end else begin
                        o_shift.operand = 32'd0;
                        o_shift.carry   = (amt_reg == 8'd32) ? sign : 1'b0;
                    end
                end
                adp_alu_pkg::SH_ASR: begin
                    if (amt_reg < 8'd32) begin
                        o_shift.operand = val_asr;
                        o_shift.carry   = c_right;
                    end else begin
                        o_shift.operand = {32{sign}};
                        o_shift.carry   = sign;
                    end
                end
                default: begin
                    o_shift.operand = amt_zero ? rm : val_ror;
                    o_shift.carry   = amt_zero ? sign : c_right;
                end
            endcase
        end
    end

endmodule

[hw/rtl/adp_alu_exec.sv]
module adp_alu_exec (
    input  adp_alu_pkg::t_alu_in    i_item,
    input  adp_alu_pkg::t_shift_res i_shift,
    output adp_alu_pkg::t_alu_out   o_result
);

    logic [31:0] rn;
    logic [31:0] op2;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic        add_cin;
    logic [32:0] sum;
    logic        add_v;
    logic [31:0] res;
    logic        res_c;
    logic        res_v;
    logic        is_test;

    assign rn  = i_item.operand_first;
    assign op2 = i_shift.operand;

    // Adder operand selection; reverse forms swap the operands.
    always_comb begin
        add_a   = rn;
        add_b   = ~op2;
        add_cin = 1'b1;
        case (i_item.opcode)
            adp_alu_pkg::OP_RSB: begin
                add_a = op2;
                add_b = ~rn;
            end
            adp_alu_pkg::OP_RSC: begin
                add_a   = op2;
                add_b   = ~rn;
                add_cin = i_item.carry_in;
            end
            adp_alu_pkg::OP_ADD, adp_alu_pkg::OP_CMN: begin
                add_b   = op2;
                add_cin = 1'b0;
            end
            adp_alu_pkg::OP_ADC: begin
                add_b   = op2;
                add_cin = i_item.carry_in;
            end
            adp_alu_pkg::OP_SBC: begin
                add_cin = i_item.carry_in;
            end
            default: begin
            end
        endcase
    end

    // One shared 32-bit adder with carry and signed overflow.
    assign sum   = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
    assign add_v = ~(add_a[31] ^ add_b[31]) & (add_a[31] ^ sum[31]);

    // Operation decode.
    always_comb begin
        res   = sum[31:0];
        res_c = sum[32];
        res_v = add_v;
        unique case (i_item.opcode) inside
            adp_alu_pkg::OP_AND, adp_alu_pkg::OP_TST: begin
                res   = rn & op2;
                res_c = i_shift.carry;
                res_v = i_item.overflow_in;
            end
            adp_alu_pkg::OP_EOR, adp_alu_pkg::OP_TEQ: begin
                res   = rn ^ op2;
                res_c = i_shift.carry;
                res_v = i_item.overflow_in;
            end
            adp_alu_pkg::OP_ORR: begin
                res   = rn | op2;
                res_c = i_shift.carry;
                res_v = i_item.overflow_in;
            end
            adp_alu_pkg::OP_MOV: begin
                res   = op2;
                res_c = i_shift.carry;
                res_v = i_item.overflow_in;
            end
            adp_alu_pkg::OP_BIC: begin
                res   = rn & ~op2;
                res_c = i_shift.carry;
                res_v = i_item.overflow_in;
            end
            adp_alu_pkg::OP_MVN: begin
                res   = ~op2;
                res_c = i_shift.carry;
                res_v = i_item.overflow_in;
            end
            default: begin
            end
        endcase
    end

    // Compares and tests do not write the destination.
    assign is_test = (i_item.opcode == adp_alu_pkg::OP_TST) ||
                     (i_item.opcode == adp_alu_pkg::OP_TEQ) ||
                     (i_item.opcode == adp_alu_pkg::OP_CMP) ||
                     (i_item.opcode == adp_alu_pkg::OP_CMN);

    // Flags read as zero when the S bit is clear.
    always_comb begin
        o_result.result       = res;
        o_result.write_result = ~is_test;
        o_result.flags_write  = i_item.set_flags;
        o_result.flag_n       = i_item.set_flags & res[31];
        o_result.flag_z       = i_item.set_flags & (res == 32'd0);
        o_result.flag_c       = i_item.set_flags & res_c;
        o_result.flag_v       = i_item.set_flags & res_v;
    end

endmodule

[tb/testbench.sv]
module testbench;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    adp_alu_pkg::t_alu_in  i_item;
    logic                  o_valid;
    adp_alu_pkg::t_alu_out o_result;

    // Results predicted for accepted items, oldest first.
    adp_alu_pkg::t_alu_out expected_results[$];
    int unsigned           items_accepted;
    int unsigned           results_checked;
    int unsigned           error_count;
    int unsigned           sender_idle_pct;

    arm_data_processing_alu_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block never drains.
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Rotate right by any amount, taken modulo 32.
    function automatic logic [31:0] rotate_right(input logic [31:0] x, input int unsigned n);
        logic [63:0] wide;
        wide = {x, x} >> (n % 32);
        return wide[31:0];
    endfunction

    // Barrel shifter: second operand and its carry-out.
    function automatic adp_alu_pkg::t_shift_res shift_operand(input adp_alu_pkg::t_alu_in it);
        adp_alu_pkg::t_shift_res sr;
        logic [31:0]             rm;
        logic [31:0]             asr_val;
        logic                    sign;
        int unsigned             n;
        int unsigned             m;
        rm   = it.operand_second;
        sign = rm[31];
        if (it.immediate_form) begin
            n = it.rotate_amount * 2;
            sr.operand = rotate_right({24'h0, rm[7:0]}, n);
            sr.carry   = (n == 0) ? it.carry_in : sr.operand[31];
        end else if (!it.shift_by_register) begin
            // A zero immediate amount encodes LSR #32, ASR #32 or RRX.
            n = 32'(it.shift_amount[4:0]);
            case (it.shift_kind)
                adp_alu_pkg::SH_LSL: begin
                    sr.operand = rm << n;
                    sr.carry   = (n == 0) ? it.carry_in : rm[32 - n];
                end
                adp_alu_pkg::SH_LSR: begin
                    sr.operand = (n == 0) ? 32'h0 : rm >> n;
                    sr.carry   = (n == 0) ? sign : rm[n - 1];
                end
                adp_alu_pkg::SH_ASR: begin
                    asr_val    = $signed(rm) >>> n;
                    sr.operand = (n == 0) ? {32{sign}} : asr_val;
                    sr.carry   = (n == 0) ? sign : rm[n - 1];
                end
                default: begin
                    sr.operand = (n == 0) ? {it.carry_in, rm[31:1]} : rotate_right(rm, n);
                    sr.carry   = (n == 0) ? rm[0] : rm[n - 1];
                end
            endcase
        end else begin
            // Register amounts use the whole byte; zero leaves everything alone.
            n = 32'(it.shift_amount);
            if (n == 0) begin
                sr.operand = rm;
                sr.carry   = it.carry_in;
            end else begin
                case (it.shift_kind)
                    adp_alu_pkg::SH_LSL: begin
                        sr.operand = (n < 32) ? rm << n : 32'h0;
                        sr.carry   = (n < 32) ? rm[32 - n] : ((n == 32) ? rm[0] : 1'b0);
                    end
                    adp_alu_pkg::SH_LSR: begin
                        sr.operand = (n < 32) ? rm >> n : 32'h0;
                        sr.carry   = (n < 32) ? rm[n - 1] : ((n == 32) ? sign : 1'b0);
                    end
                    adp_alu_pkg::SH_ASR: begin
                        asr_val    = $signed(rm) >>> n;
                        sr.operand = (n < 32) ? asr_val : {32{sign}};
                        sr.carry   = (n < 32) ? rm[n - 1] : sign;
                    end
                    default: begin
                        m = n % 32;
                        sr.operand = rotate_right(rm, m);
                        sr.carry   = (m == 0) ? sign : rm[m - 1];
                    end
                endcase
            end
        end
        return sr;
    endfunction

    // Adder giving {overflow, carry, sum}.
    function automatic logic [33:0] add_with_carry(input logic [31:0] a, input logic [31:0] b,
                                                   input logic c);
        logic [32:0] sum;
        logic        ovf;
        sum = {1'b0, a} + {1'b0, b} + {32'h0, c};
        ovf = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
        return {ovf, sum};
    endfunction

    // Expected result of one instruction.
    function automatic adp_alu_pkg::t_alu_out predict_alu(input adp_alu_pkg::t_alu_in it);
        adp_alu_pkg::t_alu_out   res;
        adp_alu_pkg::t_shift_res sr;
        logic [31:0]             rn;
        logic [33:0]             acc;
        logic                    arith;
        sr    = shift_operand(it);
        rn    = it.operand_first;
        arith = 1'b1;
        acc   = '0;
        case (it.opcode)
            adp_alu_pkg::OP_SUB, adp_alu_pkg::OP_CMP:
                acc = add_with_carry(rn, ~sr.operand, 1'b1);
            adp_alu_pkg::OP_RSB:
                acc = add_with_carry(sr.operand, ~rn, 1'b1);
            adp_alu_pkg::OP_ADD, adp_alu_pkg::OP_CMN:
                acc = add_with_carry(rn, sr.operand, 1'b0);
            adp_alu_pkg::OP_ADC:
                acc = add_with_carry(rn, sr.operand, it.carry_in);
            adp_alu_pkg::OP_SBC:
                acc = add_with_carry(rn, ~sr.operand, it.carry_in);
            adp_alu_pkg::OP_RSC:
                acc = add_with_carry(sr.operand, ~rn, it.carry_in);
            default: begin
                arith = 1'b0;
                case (it.opcode)
                    adp_alu_pkg::OP_AND, adp_alu_pkg::OP_TST: acc[31:0] = rn & sr.operand;
                    adp_alu_pkg::OP_EOR, adp_alu_pkg::OP_TEQ: acc[31:0] = rn ^ sr.operand;
                    adp_alu_pkg::OP_ORR: acc[31:0] = rn | sr.operand;
                    adp_alu_pkg::OP_MOV: acc[31:0] = sr.operand;
                    adp_alu_pkg::OP_BIC: acc[31:0] = rn & ~sr.operand;
                    default:             acc[31:0] = ~sr.operand;
                endcase
            end
        endcase
        res.result       = acc[31:0];
        res.write_result = !(it.opcode == adp_alu_pkg::OP_TST ||
                             it.opcode == adp_alu_pkg::OP_TEQ ||
                             it.opcode == adp_alu_pkg::OP_CMP ||
                             it.opcode == adp_alu_pkg::OP_CMN);
        res.flags_write  = it.set_flags;
        res.flag_n       = it.set_flags & acc[31];
        res.flag_z       = it.set_flags & (acc[31:0] == 32'h0);
        res.flag_c       = it.set_flags & (arith ? acc[32] : sr.carry);
        res.flag_v       = it.set_flags & (arith ? acc[33] : it.overflow_in);
        return res;
    endfunction

    // Compare one field and report a mismatch.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
            error_count++;
        end
    endtask

    // Result checker and predictor, both on the rising edge.
    always @(posedge i_clk) begin
        adp_alu_pkg::t_alu_out want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("result 0x%08h arrived with no item outstanding", o_result.result);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("result", want.result, o_result.result);
                check_field("write_result", 32'(want.write_result),
                            32'(o_result.write_result));
                check_field("flags_write", 32'(want.flags_write), 32'(o_result.flags_write));
                check_field("flag_n", 32'(want.flag_n), 32'(o_result.flag_n));
                check_field("flag_z", 32'(want.flag_z), 32'(o_result.flag_z));
                check_field("flag_c", 32'(want.flag_c), 32'(o_result.flag_c));
                check_field("flag_v", 32'(want.flag_v), 32'(o_result.flag_v));
                results_checked++;
            end
        end
        if (i_rst_n && start && !busy) begin
            expected_results.push_back(predict_alu(i_item));
            items_accepted++;
        end
    end

    // Send one item, with random idle cycles ahead of it.
    task automatic send_item(input adp_alu_pkg::t_alu_in item);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= item;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic adp_alu_pkg::t_alu_in make_reg_item(input logic [3:0] op,
                                                           input logic [31:0] rn,
                                                           input logic [31:0] rm,
                                                           input logic [1:0] kind,
                                                           input logic [7:0] amount,
                                                           input logic by_reg,
                                                           input logic cin,
                                                           input logic vin,
                                                           input logic s_bit);
        adp_alu_pkg::t_alu_in it;
        it = '0;
        it.opcode            = op;
        it.operand_first     = rn;
        it.operand_second    = rm;
        it.shift_kind        = kind;
        it.shift_amount      = amount;
        it.shift_by_register = by_reg;
        it.carry_in          = cin;
        it.overflow_in       = vin;
        it.set_flags         = s_bit;
        return it;
    endfunction

    function automatic adp_alu_pkg::t_alu_in make_imm_item(input logic [3:0] op,
                                                           input logic [31:0] rn,
                                                           input logic [31:0] imm,
                                                           input logic [3:0] rot,
                                                           input logic cin,
                                                           input logic vin);
        adp_alu_pkg::t_alu_in it;
        it = '0;
        it.opcode         = op;
        it.operand_first  = rn;
        it.operand_second = imm;
        it.immediate_form = 1'b1;
        it.rotate_amount  = rot;
        it.carry_in       = cin;
        it.overflow_in    = vin;
        it.set_flags      = 1'b1;
        return it;
    endfunction

    // Operand values weighted towards the corners.
    function automatic logic [31:0] random_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    function automatic adp_alu_pkg::t_alu_in random_item();
        adp_alu_pkg::t_alu_in it;
        it.opcode            = 4'($urandom_range(15));
        it.operand_first     = random_word();
        it.operand_second    = random_word();
        it.immediate_form    = ($urandom_range(3) == 0);
        it.shift_kind        = 2'($urandom_range(3));
        it.shift_by_register = 1'($urandom_range(1));
        case ($urandom_range(9))
            0:       it.shift_amount = 8'd0;
            1:       it.shift_amount = 8'd32;
            2:       it.shift_amount = 8'($urandom_range(33, 255));
            3:       it.shift_amount = 8'($urandom_range(1, 7) * 32);
            default: it.shift_amount = 8'($urandom_range(255));
        endcase
        it.rotate_amount = 4'($urandom_range(15));
        it.carry_in      = 1'($urandom_range(1));
        it.overflow_in   = 1'($urandom_range(1));
        it.set_flags     = ($urandom_range(9) != 0);
        return it;
    endfunction

    // Every operation once, with operands that hit carry, overflow and zero.
    task automatic test_all_operations();
        sender_idle_pct = 0;
        send_item(make_reg_item(adp_alu_pkg::OP_AND, 32'hFFFF_FFFF, 32'h0,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b0, 1'b1, 1'b0, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_EOR, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b0, 1'b0, 1'b1, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_SUB, 32'h0, 32'h1,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b0, 1'b1, 1'b0, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_RSB, 32'h1, 32'h0,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h1,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_ADC, 32'hFFFF_FFFF, 32'h0,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b0, 1'b1, 1'b0, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_SBC, 32'h8000_0000, 32'h1,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_RSC, 32'h0, 32'h0,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b0, 1'b0, 1'b1, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_TST, 32'h8000_0000, 32'h8000_0000,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_TEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_CMP, 32'h5, 32'h5,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_CMN, 32'hFFFF_FFFF, 32'h1,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b0, 1'b0, 1'b1, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_ORR, 32'h0, 32'h0,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b0, 1'b1, 1'b1, 1'b1));
        // Flags left alone: every flag field reads zero.
        send_item(make_reg_item(adp_alu_pkg::OP_MOV, 32'h0, 32'h8000_0000,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0));
        send_item(make_reg_item(adp_alu_pkg::OP_BIC, 32'hFFFF_FFFF, 32'h0F0F_0F0F,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_MVN, 32'h0, 32'h0,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b0, 1'b0, 1'b1, 1'b1));
    endtask

    // Shift amounts of zero, 32 and beyond, and the immediate rotate.
    task automatic test_shifter_corners();
        sender_idle_pct = 0;
        // Immediate zero amounts: LSR #32, ASR #32, RRX, and LSL with unused bits set.
        send_item(make_reg_item(adp_alu_pkg::OP_MOV, 32'h0, 32'h8000_0001,
                                adp_alu_pkg::SH_LSR, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_MOV, 32'h0, 32'h8000_0001,
                                adp_alu_pkg::SH_ASR, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_MOV, 32'h0, 32'h8000_0001,
                                adp_alu_pkg::SH_ROR, 8'd0, 1'b0, 1'b1, 1'b0, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_MOV, 32'h0, 32'h8000_0001,
                                adp_alu_pkg::SH_LSL, 8'hE0, 1'b0, 1'b1, 1'b0, 1'b1));
        // Register amounts: zero, exactly 32, and above 32.
        send_item(make_reg_item(adp_alu_pkg::OP_MOV, 32'h0, 32'h8000_0001,
                                adp_alu_pkg::SH_LSL, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_MOV, 32'h0, 32'h8000_0001,
                                adp_alu_pkg::SH_LSL, 8'd32, 1'b1, 1'b0, 1'b0, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_MOV, 32'h0, 32'h8000_0001,
                                adp_alu_pkg::SH_LSR, 8'd33, 1'b1, 1'b1, 1'b0, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_MOV, 32'h0, 32'h8000_0001,
                                adp_alu_pkg::SH_ASR, 8'd200, 1'b1, 1'b0, 1'b0, 1'b1));
        send_item(make_reg_item(adp_alu_pkg::OP_MOV, 32'h0, 32'h8000_0001,
                                adp_alu_pkg::SH_ROR, 8'd64, 1'b1, 1'b0, 1'b0, 1'b1));
        // Immediates: zero rotate keeps the carry, otherwise bit 31 is the carry.
        send_item(make_imm_item(adp_alu_pkg::OP_MOV, 32'h0, 32'hFFFF_FFAB, 4'd0, 1'b1, 1'b0));
        send_item(make_imm_item(adp_alu_pkg::OP_ORR, 32'h1, 32'h0000_0003, 4'd1, 1'b0, 1'b1));
    endtask

    // Random instructions with the given share of idle cycles.
    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned count);
        int unsigned k;
        sender_idle_pct = idle_pct;
        for (k = 0; k < count; k++) begin
            send_item(random_item());
        end
    endtask

    initial begin
        int unsigned guard;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_item          = '0;
        items_accepted  = 0;
        results_checked = 0;
        error_count     = 0;
        sender_idle_pct = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_all_operations();
        test_shifter_corners();
        test_random_traffic(0, 225);
        test_random_traffic(71, 225);
        // The receiver cannot hold results off, so this phase runs back to back.
        test_random_traffic(0, 225);
        test_random_traffic(10, 225);

        @(negedge i_clk);
        start <= 1'b0;

        // Drain the pipeline, then allow for its latency.
        guard = 0;
        while (expected_results.size() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            error_count++;
        end

        $display("Sent %0d items over all sixteen operations and every shifter form;",
                 items_accepted);
        $display("checked %0d results with %0d errors.", results_checked, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
